// ===== sv/injac_pkg.sv =====
// ----------------------------------------------------------------------------
// injac_pkg: shared types and constants
// Fixed field widths, result kinds and the configuration register indices.
// ----------------------------------------------------------------------------
`default_nettype none
package injac_pkg;
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned IDX_W   = 11;
	localparam int unsigned KIND_W  = 2;
	localparam int unsigned CFG_W   = 32;
	localparam int unsigned CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_CELL_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INLET_PT   = 1'd1;

	localparam logic signed [VALUE_W-1:0] Q_ONE     = 32'sh0001_0000;
	localparam logic signed [VALUE_W-1:0] Q_NEG_ONE = 32'shFFFF_0000;

	typedef enum logic [KIND_W-1:0] {
		KIND_MATRIX  = 2'd0,
		KIND_RHS     = 2'd1,
		KIND_MOM_RMS = 2'd2,
		KIND_CON_RMS = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t                     kind;
		logic [IDX_W-1:0]          row;
		logic [IDX_W-1:0]          column;
		logic signed [VALUE_W-1:0] value;
		logic                      last;
	} result_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] density;
		logic signed [VALUE_W-1:0] velocity;
		logic signed [VALUE_W-1:0] pressure;
		logic signed [VALUE_W-1:0] area;
	} cell_t;

	// Saturate a 64-bit signed value to 32 bits
	function automatic logic signed [VALUE_W-1:0] sat32(input logic signed [63:0] v);
		logic signed [VALUE_W-1:0] r;
		if (v > 64'sh0000_0000_7FFF_FFFF)
			r = 32'sh7FFF_FFFF;
		else if (v < -64'sh0000_0000_8000_0000)
			r = 32'sh8000_0000;
		else
			r = v[VALUE_W-1:0];
		return r;
	endfunction
endpackage
`default_nettype wire

// ===== sv/injac_if.sv =====
// ----------------------------------------------------------------------------
// injac_stream_if: valid/ready channel
// Carries one payload per transaction.
// ----------------------------------------------------------------------------
`default_nettype none
interface injac_stream_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/injac_sqrt.sv =====
// ----------------------------------------------------------------------------
// injac_sqrt: iterative divide and square root
// Restoring divide of a 64-bit sum by an 11-bit count, then a
// two-bit-per-cycle integer square root.
// ----------------------------------------------------------------------------
`default_nettype none
module injac_sqrt (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] sum,
	input  wire logic [10:0] divisor,
	output logic             done,
	output logic [31:0]      root
);
	import injac_pkg::*;

	typedef enum logic [2:0] {
		SQ_IDLE = 3'b001,
		SQ_DIV  = 3'b010,
		SQ_ROOT = 3'b100
	} sq_state_t;

	sq_state_t   state_q;
	logic [63:0] quo_q;
	logic [10:0] rem_q;
	logic [10:0] div_q;
	logic [5:0]  cnt_q;
	logic [63:0] num_q;
	logic [63:0] res_q;
	logic [63:0] bit_q;
	logic [11:0] rem_sh;
	logic [63:0] trial;

	assign rem_sh = {rem_q, quo_q[63]};
	assign trial  = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
			done    <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				SQ_IDLE: begin
					if (start) begin
						state_q <= SQ_DIV;
						cnt_q   <= '0;
					end
				end
				SQ_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) state_q <= SQ_ROOT;
				end
				SQ_ROOT: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd31) begin
						state_q <= SQ_IDLE;
						done    <= 1'b1;
					end
				end
				default: state_q <= SQ_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			SQ_IDLE: begin
				quo_q <= sum;
				rem_q <= '0;
				div_q <= divisor;
			end
			SQ_DIV: begin
				if (rem_sh >= {1'b0, div_q}) begin
					rem_q <= 11'(rem_sh - {1'b0, div_q});
					quo_q <= {quo_q[62:0], 1'b1};
				end else begin
					rem_q <= rem_sh[10:0];
					quo_q <= {quo_q[62:0], 1'b0};
				end
				if (cnt_q == 6'd63) begin
					res_q <= '0;
					bit_q <= 64'h4000_0000_0000_0000;
				end
			end
			SQ_ROOT: begin
				if (cnt_q == 6'd0) num_q <= quo_q;
				if (cnt_q != 6'd0) begin
					if (num_q >= trial) begin
						num_q <= num_q - trial;
						res_q <= (res_q >> 1) + bit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q <= bit_q >> 2;
				end
			end
			default: ;
		endcase
	end

	// The root state first only loads the radicand, then 31 registered steps
	// follow, and the 32nd step is formed here
	logic [63:0] res_fin;
	always_comb begin
		res_fin = res_q;
		if (num_q >= trial) res_fin = (res_q >> 1) + bit_q;
		else res_fin = res_q >> 1;
		root = (res_fin > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : res_fin[31:0];
	end
endmodule
`default_nettype wire

// ===== sv/injac_mul.sv =====
// ----------------------------------------------------------------------------
// injac_mul: shared Q16.16 multiplier
// Registered signed product, floor-shifted by 16 and saturated.
// ----------------------------------------------------------------------------
`default_nettype none
module injac_mul (
	input  wire logic               clk,
	input  wire logic signed [31:0] a,
	input  wire logic signed [31:0] b,
	output logic signed [31:0]      prod,
	output logic [63:0]             square
);
	import injac_pkg::*;
	logic signed [63:0] p_s1;
	always_ff @(posedge clk) p_s1 <= 64'(a) * 64'(b);
	// Arithmetic shift is floor division by 2^16
	assign prod   = sat32(p_s1 >>> 16);
	assign square = p_s1;
endmodule
`default_nettype wire

// ===== sv/incompressible_nozzle_jacobian_assembly_top.sv =====
// ----------------------------------------------------------------------------
// incompressible_nozzle_jacobian_assembly_top: nozzle system assembler
// Streams cells in and tagged matrix and rhs transactions out.
// ----------------------------------------------------------------------------
// Flow: a cell is taken only in the idle state. The shared multiplier steps
// run first; the cell's results then leave through the output register one
// per cycle while the receiver is ready (3 or 8 results), and only then is
// the next cell taken. A last cell emits 10 results, runs the divide and
// square-root unit twice, then emits the two rms results.
// Reset: asynchronous, clears previous cell, counter, sums and registers.
// ----------------------------------------------------------------------------
`default_nettype none
module incompressible_nozzle_jacobian_assembly_top #(
	parameter int unsigned MAX_CELLS = 1024
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	injac_stream_if.sink              in_ch,
	injac_stream_if.source            out_ch,
	input  wire logic                 cfg_we,
	input  wire logic [injac_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [injac_pkg::CFG_W-1:0]     cfg_data
);
	import injac_pkg::*;

	localparam logic [IDX_W-1:0] MAXC =
		(MAX_CELLS > 1024) ? IDX_W'(1024) : IDX_W'(MAX_CELLS);

	// Sequencer states
	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_MUL  = 6'b000010,
		S_EMIT = 6'b000100,
		S_SQRT = 6'b001000,
		S_WAIT = 6'b010000,
		S_RMS  = 6'b100000
	} state_t;

	state_t state_q;

	logic [IDX_W-1:0]          cell_count_q;
	logic signed [VALUE_W-1:0] ptin_q;
	cell_t                     cur_q, prev_q;
	logic [IDX_W-1:0]          idx_q;
	logic [63:0]               msum_q, csum_q;
	logic [3:0]                step_q;
	logic [3:0]                emit_q;
	logic signed [VALUE_W-1:0] m_q, g_q, mp_q, gp_q, r_q, t1_q, t2_q;
	logic signed [VALUE_W-1:0] rhs0_q, rhsm_q, rhsc_q;
	logic [31:0]               mrms_q;
	logic                      rms_sel_q;
	logic                      last_q;
	logic [IDX_W-1:0]          n_q;

	// Effective count, clamped to the legal range
	logic [IDX_W-1:0] n_eff;
	always_comb begin
		n_eff = cell_count_q;
		if (n_eff < 11'd2) n_eff = 11'd2;
		if (n_eff > MAXC) n_eff = MAXC;
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_count_q <= 11'd2;
			ptin_q       <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CELL_COUNT: cell_count_q <= cfg_data[IDX_W-1:0];
				REG_INLET_PT:   ptin_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	// Shared multiplier operand selection, one product per step
	logic signed [31:0] ma, mb, mprod;
	logic [63:0]        msq;
	always_comb begin
		ma = cur_q.density; mb = cur_q.velocity;
		case (step_q)
			4'd0: begin ma = cur_q.density;   mb = cur_q.velocity;  end
			4'd1: begin ma = cur_q.area;      mb = cur_q.density;   end
			4'd2: begin ma = prev_q.density;  mb = prev_q.velocity; end
			4'd3: begin ma = prev_q.area;     mb = prev_q.density;  end
			4'd4: begin ma = m_q;             mb = cur_q.velocity;  end
			4'd5: begin ma = r_q;             mb = cur_q.velocity;  end
			4'd6: begin ma = r_q;             mb = prev_q.velocity; end
			4'd7: begin ma = gp_q;            mb = prev_q.velocity; end
			4'd8: begin ma = g_q;             mb = cur_q.velocity;  end
			4'd9: begin ma = rhs0_q;          mb = rhs0_q;          end
			4'd10: begin ma = rhsm_q;         mb = rhsm_q;          end
			4'd11: begin ma = rhsc_q;         mb = rhsc_q;          end
			default: ;
		endcase
	end

	injac_mul u_mul (.clk(clk), .a(ma), .b(mb), .prod(mprod), .square(msq));

	// Products are registered: pstep names the step whose product is on mprod
	logic [3:0] pstep;
	assign pstep = step_q - 4'd1;

	// Mean mass flux: previous and current products, both held by now
	logic signed [63:0] mm_sum;
	assign mm_sum = 64'(mp_q) + 64'(m_q);

	function automatic logic [63:0] addsat(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? '1 : s[63:0];
	endfunction

	// Divide and root unit
	logic        sq_start, sq_done;
	logic [31:0] sq_root;
	injac_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start),
		.sum(rms_sel_q ? csum_q : msum_q), .divisor(n_q - 11'd1),
		.done(sq_done), .root(sq_root)
	);
	assign sq_start = (state_q == S_SQRT);

	// Result list of the current cell, indexed by the emit counter
	result_t res;
	logic [3:0] nres;
	logic [IDX_W-1:0] i_m1, np_i, np_im1;
	assign i_m1   = idx_q - 11'd1;
	assign np_i   = n_q + idx_q;
	assign np_im1 = n_q + idx_q - 11'd1;
	logic first;
	assign first = (idx_q == '0);

	always_comb begin
		res = '{kind: KIND_MATRIX, row: '0, column: '0, value: '0, last: 1'b0};
		if (first) begin
			case (emit_q)
				4'd0: res = '{KIND_MATRIX, 11'd0, 11'd0, m_q, 1'b0};
				4'd1: res = '{KIND_MATRIX, 11'd0, n_q, Q_ONE, 1'b0};
				4'd2: res = '{KIND_RHS, 11'd0, 11'd0, rhs0_q, 1'b0};
				4'd3: res = '{KIND_MATRIX, np_i, np_i, g_q, 1'b0};
				4'd4: res = '{KIND_RHS, np_i, 11'd0, '0, 1'b0};
				default: ;
			endcase
		end else begin
			case (emit_q)
				4'd0: res = '{KIND_MATRIX, idx_q, i_m1, sat32(-64'(r_q)), 1'b0};
				4'd1: res = '{KIND_MATRIX, idx_q, idx_q, r_q, 1'b0};
				4'd2: res = '{KIND_MATRIX, idx_q, np_im1, Q_NEG_ONE, 1'b0};
				4'd3: res = '{KIND_MATRIX, idx_q, np_i, Q_ONE, 1'b0};
				4'd4: res = '{KIND_RHS, idx_q, 11'd0, rhsm_q, 1'b0};
				4'd5: res = '{KIND_MATRIX, np_im1, i_m1, gp_q, 1'b0};
				4'd6: res = '{KIND_MATRIX, np_im1, idx_q, sat32(-64'(g_q)), 1'b0};
				4'd7: res = '{KIND_RHS, np_im1, 11'd0, rhsc_q, 1'b0};
				4'd8: res = '{KIND_MATRIX, np_i, np_i, g_q, 1'b0};
				4'd9: res = '{KIND_RHS, np_i, 11'd0, '0, 1'b0};
				default: ;
			endcase
		end
		nres = first ? (last_q ? 4'd5 : 4'd3) : (last_q ? 4'd10 : 4'd8);
		if (!last_q && emit_q == nres - 4'd1) res.last = 1'b1;
	end

	// Output holding register
	result_t out_q;
	logic    out_v_q;
	assign out_ch.valid = out_v_q;
	assign out_ch.data  = out_q;
	assign in_ch.ready  = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_v_q   <= 1'b0;
			prev_q    <= '0;
			idx_q     <= '0;
			msum_q    <= '0;
			csum_q    <= '0;
			step_q    <= '0;
			emit_q    <= '0;
			rms_sel_q <= 1'b0;
			last_q    <= 1'b0;
			n_q       <= 11'd2;
		end else begin
			if (out_v_q && out_ch.ready) out_v_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						cur_q   <= in_ch.data;
						n_q     <= n_eff;
						last_q  <= ({1'b0, idx_q} + 12'd1 >= {1'b0, n_eff});
						step_q  <= '0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					step_q <= step_q + 4'd1;
					case (pstep)
						4'd0: m_q  <= mprod;
						4'd1: g_q  <= mprod;
						4'd2: mp_q <= mprod;
						4'd3: begin
							gp_q <= mprod;
							r_q  <= mm_sum[32:1];
						end
						4'd4: rhs0_q <= sat32(64'(ptin_q) - 64'(cur_q.pressure)
							- 64'(mprod >>> 1));
						4'd5: t1_q <= mprod;
						4'd6: rhsm_q <= sat32(-(64'(t1_q) - 64'(mprod)
							+ 64'(cur_q.pressure) - 64'(prev_q.pressure)));
						4'd7: t2_q <= mprod;
						4'd8: rhsc_q <= sat32(-(64'(t2_q) - 64'(mprod)));
						4'd9: if (first) msum_q <= addsat(msum_q, msq);
						4'd10: if (!first) msum_q <= addsat(msum_q, msq);
						4'd11: begin
							if (!first) csum_q <= addsat(csum_q, msq);
							emit_q  <= '0;
							state_q <= S_EMIT;
						end
						default: ;
					endcase
				end
				S_EMIT: begin
					if (!out_v_q || out_ch.ready) begin
						out_q   <= res;
						out_v_q <= 1'b1;
						emit_q  <= emit_q + 4'd1;
						if (emit_q == nres - 4'd1) begin
							prev_q <= cur_q;
							if (last_q) begin
								rms_sel_q <= 1'b0;
								state_q   <= S_SQRT;
							end else begin
								idx_q   <= idx_q + 11'd1;
								state_q <= S_IDLE;
							end
						end
					end
				end
				S_SQRT: state_q <= S_WAIT;
				S_WAIT: begin
					if (sq_done) begin
						if (!rms_sel_q) begin
							mrms_q    <= sq_root;
							rms_sel_q <= 1'b1;
							state_q   <= S_SQRT;
						end else begin
							state_q <= S_RMS;
							emit_q  <= '0;
						end
					end
				end
				S_RMS: begin
					if (!out_v_q || out_ch.ready) begin
						out_v_q <= 1'b1;
						emit_q  <= emit_q + 4'd1;
						if (emit_q == '0) begin
							out_q <= '{KIND_MOM_RMS, 11'd0, 11'd0, mrms_q, 1'b0};
						end else begin
							// Hold the continuity root until now; close the pass
							out_q   <= '{KIND_CON_RMS, 11'd0, 11'd0, sq_root, 1'b1};
							idx_q   <= '0;
							msum_q  <= '0;
							csum_q  <= '0;
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== sv/injac_checker.sv =====
// ----------------------------------------------------------------------------
// injac_checker: port-level checks
// Watches the top level's channels and binds to it.
// ----------------------------------------------------------------------------
`default_nettype none
module injac_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic out_last,
	input wire logic [1:0] out_kind
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("accepted while busy");
	a_con_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == 2'd3 |-> out_last) else $error("rms not last");
	// Ready for a cell only when no transaction is pending or the pending one is the previous cell's final one
	a_idle_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid || out_last)
		else $error("ready before cell closed");
endmodule

bind incompressible_nozzle_jacobian_assembly_top injac_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_last(out_ch.data.last), .out_kind(out_ch.data.kind)
);
`default_nettype wire

// ===== verif/injac_tb_if.sv =====
// ----------------------------------------------------------------------------
// Scoreboard package for the assembler testbench
// The testbench uses the channel interface defined with the block.
// ----------------------------------------------------------------------------
`default_nettype none
package injac_tb_pkg;
	import injac_pkg::*;

	// Scoreboard: predicts the results of each accepted cell and checks them
	class nozzle_scoreboard;
		logic [10:0] cell_count_reg;
		logic signed [31:0] inlet_pt_reg;
		logic signed [31:0] prev_rho, prev_u, prev_p, prev_a;
		int unsigned cell_pos;
		logic [63:0] mom_sum, con_sum;
		result_t pending_results[$];
		int errors;

		function new();
			cell_count_reg = 11'd2;
			inlet_pt_reg = '0;
			prev_rho = '0;
			prev_u = '0;
			prev_p = '0;
			prev_a = '0;
			cell_pos = 0;
			mom_sum = '0;
			con_sum = '0;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
			if (idx == REG_CELL_COUNT)
				cell_count_reg = d[10:0];
			else
				inlet_pt_reg = d;
		endfunction

		function logic signed [31:0] clip(logic signed [63:0] v);
			if (v > 64'sh7FFF_FFFF)
				return 32'sh7FFF_FFFF;
			if (v < -64'sh8000_0000)
				return 32'sh8000_0000;
			return v[31:0];
		endfunction

		// Arithmetic shift is a floor for signed values
		function logic signed [31:0] qprod(logic signed [31:0] x, logic signed [31:0] y);
			logic signed [63:0] p;
			p = 64'(x) * 64'(y);
			return clip(p >>> 16);
		endfunction

		function logic [63:0] sum_sq(logic [63:0] acc, logic signed [31:0] v);
			logic [64:0] s;
			logic signed [63:0] sq;
			sq = 64'(v) * 64'(v);
			s = {1'b0, acc} + {1'b0, sq};
			return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
		endfunction

		function logic signed [31:0] root_mean(logic [63:0] sum, int unsigned n);
			logic [63:0] q, r, b;
			q = sum / 64'(n - 1);
			r = 0;
			b = 64'h1 << 62;
			while (b > q)
				b = b >> 2;
			while (b != 0) begin
				if (q >= r + b) begin
					q = q - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return (r > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : r[31:0];
		endfunction

		function void push(kind_t k, int unsigned row, int unsigned col,
				logic signed [31:0] v);
			result_t t;
			t.kind = k;
			t.row = row[10:0];
			t.column = col[10:0];
			t.value = v;
			t.last = 1'b0;
			pending_results.push_back(t);
		endfunction

		function void note_cell(cell_t c);
			int unsigned n, i;
			logic signed [31:0] m, g, mp, r, gp, rhs;
			logic signed [63:0] w;
			result_t t;
			n = cell_count_reg;
			if (n < 2)
				n = 2;
			if (n > 1024)
				n = 1024;
			i = cell_pos;
			m = qprod(c.density, c.velocity);
			g = qprod(c.area, c.density);
			if (i == 0) begin
				push(KIND_MATRIX, 0, 0, m);
				push(KIND_MATRIX, 0, n, Q_ONE);
				w = 64'(inlet_pt_reg) - 64'(c.pressure) - (64'(qprod(m, c.velocity)) >>> 1);
				rhs = clip(w);
				push(KIND_RHS, 0, 0, rhs);
				mom_sum = sum_sq(mom_sum, rhs);
			end else begin
				mp = qprod(prev_rho, prev_u);
				w = (64'(mp) + 64'(m)) >>> 1;
				r = w[31:0];
				gp = qprod(prev_a, prev_rho);
				push(KIND_MATRIX, i, i - 1, clip(-64'(r)));
				push(KIND_MATRIX, i, i, r);
				push(KIND_MATRIX, i, n + i - 1, Q_NEG_ONE);
				push(KIND_MATRIX, i, n + i, Q_ONE);
				w = 64'(qprod(r, c.velocity)) - 64'(qprod(r, prev_u))
					+ 64'(c.pressure) - 64'(prev_p);
				rhs = clip(-w);
				push(KIND_RHS, i, 0, rhs);
				mom_sum = sum_sq(mom_sum, rhs);
				push(KIND_MATRIX, n + i - 1, i - 1, gp);
				push(KIND_MATRIX, n + i - 1, i, clip(-64'(g)));
				w = 64'(qprod(gp, prev_u)) - 64'(qprod(g, c.velocity));
				rhs = clip(-w);
				push(KIND_RHS, n + i - 1, 0, rhs);
				con_sum = sum_sq(con_sum, rhs);
			end
			if (i + 1 >= n) begin
				push(KIND_MATRIX, n + i, n + i, g);
				push(KIND_RHS, n + i, 0, '0);
				push(KIND_MOM_RMS, 0, 0, root_mean(mom_sum, n));
				push(KIND_CON_RMS, 0, 0, root_mean(con_sum, n));
				cell_pos = 0;
				mom_sum = '0;
				con_sum = '0;
			end else begin
				cell_pos = i + 1;
			end
			prev_rho = c.density;
			prev_u = c.velocity;
			prev_p = c.pressure;
			prev_a = c.area;
			t = pending_results.pop_back();
			t.last = 1'b1;
			pending_results.push_back(t);
		endfunction

		function void report(string what);
			$display("mismatch: %s", what);
			errors++;
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				report($sformatf("unexpected result %p", got));
				return;
			end
			want = pending_results.pop_front();
			if (got.kind != want.kind)
				report($sformatf("kind %0d, want %0d", got.kind, want.kind));
			if (got.row != want.row)
				report($sformatf("row %0d, want %0d", got.row, want.row));
			if (got.column != want.column)
				report($sformatf("column %0d, want %0d", got.column, want.column));
			if (got.value !== want.value)
				report($sformatf("value %h, want %h", got.value, want.value));
			if (got.last !== want.last)
				report($sformatf("last %b, want %b", got.last, want.last));
		endfunction
	endclass
endpackage
`default_nettype wire

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// Nozzle Jacobian assembler testbench
// Streams directed and random cells through several cell counts and inlet
// pressures, predicts every tagged transaction and checks them in order.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
	import injac_pkg::*;
	import injac_tb_pkg::*;

	localparam int STALL_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	injac_stream_if #(.payload_t(cell_t)) cell_ch ();
	injac_stream_if #(.payload_t(result_t)) result_ch ();

	nozzle_scoreboard sb;
	bit hold_sink = 0;
	bit timed_out = 0;
	int idle_cycles = 0;

	incompressible_nozzle_jacobian_assembly_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(cell_ch),
		.out_ch(result_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		cell_ch.valid = 1'b0;
		cell_ch.data = '0;
		result_ch.ready = 1'b0;
	end

	// Note accepted cells and check accepted results at each edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cell_ch.valid && cell_ch.ready)
				sb.note_cell(cell_ch.data);
			if (result_ch.valid && result_ch.ready)
				sb.check_result(result_ch.data);
			if ((cell_ch.valid && cell_ch.ready) || (result_ch.valid && result_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (idle_cycles >= STALL_LIMIT && !timed_out) begin
			timed_out = 1;
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Result side: random ready gaps, and a long hold-off when asked
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
			if (hold_sink)
				gap = 400;
			if (gap != 0) begin
				result_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			@(posedge clk);
			while (!result_ch.valid)
				@(posedge clk);
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		sb.write_reg(idx, d);
	endtask

	// Hold until every expected transaction has arrived, then let the block settle
	task automatic drain();
		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic send_cell(cell_t c, bit gaps);
		if (gaps)
			repeat ($urandom_range(0, 18)) @(posedge clk);
		cell_ch.valid <= 1'b1;
		cell_ch.data <= c;
		@(posedge clk);
		while (!cell_ch.ready)
			@(posedge clk);
		cell_ch.valid <= 1'b0;
		// The block is busy right after a transaction; step past that edge
		@(posedge clk);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom();
			default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
		endcase
	endfunction

	function automatic cell_t random_cell();
		cell_t c;
		c.density = pick_value();
		c.velocity = pick_value();
		c.pressure = pick_value();
		c.area = pick_value();
		return c;
	endfunction

	function automatic cell_t make_cell(logic [31:0] d, logic [31:0] u,
			logic [31:0] p, logic [31:0] a);
		cell_t c;
		c.density = d;
		c.velocity = u;
		c.pressure = p;
		c.area = a;
		return c;
	endfunction

	initial begin
		int count_opts[6];
		sb = new();
		count_opts = '{2, 3, 5, 1024, 0, 2047};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset count of two, extremes and saturation
		send_cell(make_cell(32'h0001_0000, 32'h0002_0000, 32'h0000_8000, 32'h0001_0000), 0);
		send_cell(make_cell(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF), 0);
		send_cell(make_cell(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000), 1);
		send_cell(make_cell(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF), 1);
		drain();
		write_reg(REG_INLET_PT, 32'h7FFF_FFFF);
		write_reg(REG_CELL_COUNT, 32'd0);
		send_cell(make_cell(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0), 0);
		send_cell(make_cell(32'h0, 32'h0, 32'h0, 32'h0), 0);
		drain();
		write_reg(REG_INLET_PT, 32'h8000_0000);
		write_reg(REG_CELL_COUNT, 32'd4);
		repeat (2) send_cell(random_cell(), 1);
		drain();
		// Lower the count mid pass: index past the new end closes the pass
		write_reg(REG_CELL_COUNT, 32'd2);
		repeat (3) send_cell(random_cell(), 1);
		drain();
		write_reg(REG_CELL_COUNT, 32'd2047);
		repeat (3) send_cell(random_cell(), 0);
		drain();

		// Pressure: hold the result side off while cells keep coming
		hold_sink = 1;
		repeat (6) send_cell(random_cell(), 0);
		hold_sink = 0;
		drain();
		write_reg(REG_CELL_COUNT, 32'd3);
		repeat (2) send_cell(random_cell(), 0);
		drain();

		// Random phases over several settings
		for (int ph = 0; ph < 10; ph++) begin
			write_reg(REG_CELL_COUNT, 32'(count_opts[$urandom_range(0, 5)]));
			write_reg(REG_INLET_PT, pick_value());
			repeat (8) send_cell(random_cell(), $urandom_range(0, 3) != 0);
			drain();
		end

		if (sb.errors == 0 && sb.pending_results.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
`default_nettype wire
